[hdl/encbtn_pkg.sv]
`timescale 1ns / 1ps

package encbtn_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_STEPS_PER_DETENT  = 3'd0;
    localparam cfg_index_t CFG_DEBOUNCE_TICKS    = 3'd1;
    localparam cfg_index_t CFG_LONG_PRESS_TICKS  = 3'd2;
    localparam cfg_index_t CFG_MIN_SHORT_TICKS   = 3'd3;
    localparam cfg_index_t CFG_SWITCH_ACTIVE_LOW = 3'd4;

    localparam logic [3:0]  RST_STEPS_PER_DETENT  = 4'd4;
    localparam logic [7:0]  RST_DEBOUNCE_TICKS    = 8'd25;
    localparam logic [15:0] RST_LONG_PRESS_TICKS  = 16'd700;
    localparam logic [15:0] RST_MIN_SHORT_TICKS   = 16'd25;
    localparam logic        RST_SWITCH_ACTIVE_LOW = 1'b1;

    localparam logic [3:0] DETENT_MIN = 4'd1;
    localparam logic [3:0] DETENT_MAX = 4'd8;

    localparam logic signed [9:0] ROT_MAX = 10'sd127;
    localparam logic signed [9:0] ROT_MIN = -10'sd127;

    localparam logic [1:0] PINS_IDLE = 2'b11;

    localparam int IN_BYTES  = 1;
    localparam int OUT_BYTES = 2;

    typedef struct packed {
        logic stable;
        logic long_taken;
        logic short_taken;
    } sw_status_t;

    // gray-code step for {previous pins, current pins}
    function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
        logic signed [1:0] s;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default:                  s = 2'sd0;
        endcase
        return s;
    endfunction

    // whole detents in a step magnitude of at most eight
    function automatic logic [3:0] detent_quot(input logic [3:0] mag, input logic [3:0] spd);
        logic [3:0] q;
        logic [7:0] prod;
        q = 4'd0;
        for (int k = 1; k <= 8; k++) begin
            prod = 8'(k) * {4'd0, spd};
            if ({4'd0, mag} >= prod) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

endpackage

[hdl/encoder_detent_and_button_events.sv]
`timescale 1ns / 1ps

// channel   dir  handshake         payload
// s_*       in   s_tvalid/tready   tick sample: pins, switch level, take flag
// m_*       out  m_tvalid/tready   taken rotation, press flags, debounced switch
// cfg_*     in   cfg_we            register index and write data
//
// one result per sample; a sample is taken every cycle while the output
// register is empty or being drained, result appears in the cycle after accept
// all tracking state updates in the accept cycle and lands in the output register
// m_tready low holds the result and blocks new samples until it is taken
// rst_n clears all state but the output data register and loads the register defaults

module encoder_detent_and_button_events
    import encbtn_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_BYTES*8-1:0]     s_tdata,   // pin_a, pin_b, switch_level, take_events
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_BYTES*8-1:0]    m_tdata,   // rotation_taken[7:0], short_taken,
                                                 // long_taken, switch_stable
    input  logic                      cfg_we,
    input  cfg_index_t                cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    logic [3:0]  steps_per_detent_reg;
    logic [7:0]  debounce_ticks_reg;
    logic [15:0] long_press_ticks_reg;
    logic [15:0] min_short_ticks_reg;
    logic        switch_active_low_reg;

    logic                   out_valid_reg;
    logic [OUT_BYTES*8-1:0] out_data_reg, out_data_next;

    logic              accept;
    logic              pin_a, pin_b, switch_level, take_events;
    logic              pressed;
    logic signed [7:0] rotation_taken;
    sw_status_t        sw_status;

    assign pin_a        = s_tdata[0];
    assign pin_b        = s_tdata[1];
    assign switch_level = s_tdata[2];
    assign take_events  = s_tdata[3];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pressed  = switch_active_low_reg ? !switch_level : switch_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            steps_per_detent_reg  <= RST_STEPS_PER_DETENT;
            debounce_ticks_reg    <= RST_DEBOUNCE_TICKS;
            long_press_ticks_reg  <= RST_LONG_PRESS_TICKS;
            min_short_ticks_reg   <= RST_MIN_SHORT_TICKS;
            switch_active_low_reg <= RST_SWITCH_ACTIVE_LOW;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_STEPS_PER_DETENT:  steps_per_detent_reg  <= cfg_wdata[3:0];
                CFG_DEBOUNCE_TICKS:    debounce_ticks_reg    <= cfg_wdata[7:0];
                CFG_LONG_PRESS_TICKS:  long_press_ticks_reg  <= cfg_wdata[15:0];
                CFG_MIN_SHORT_TICKS:   min_short_ticks_reg   <= cfg_wdata[15:0];
                CFG_SWITCH_ACTIVE_LOW: switch_active_low_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    encbtn_detent u_detent (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (accept),
        .take             (take_events),
        .pin_a            (pin_a),
        .pin_b            (pin_b),
        .steps_per_detent (steps_per_detent_reg),
        .rotation_taken   (rotation_taken)
    );

    encbtn_switch #(
        .TIMER_BITS (TIMER_BITS)
    ) u_switch (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (accept),
        .take             (take_events),
        .pressed          (pressed),
        .debounce_ticks   (debounce_ticks_reg),
        .long_press_ticks (long_press_ticks_reg),
        .min_short_ticks  (min_short_ticks_reg),
        .status           (sw_status)
    );

    always_comb
    begin
        out_data_next       = '0;
        out_data_next[7:0]  = rotation_taken;
        out_data_next[8]    = sw_status.short_taken;
        out_data_next[9]    = sw_status.long_taken;
        out_data_next[10]   = sw_status.stable;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[hdl/encbtn_detent.sv]
`timescale 1ns / 1ps

module encbtn_detent
    import encbtn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              take,
    input  logic              pin_a,
    input  logic              pin_b,
    input  logic [3:0]        steps_per_detent,
    output logic signed [7:0] rotation_taken
);

    logic [1:0]        last_pins_reg, last_pins_next;
    logic signed [3:0] step_sum_reg, step_sum_next;
    logic signed [7:0] pending_reg, pending_next;

    logic [3:0]        spd;
    logic [1:0]        pins;
    logic signed [4:0] sum5;
    logic signed [4:0] mag5;
    logic [3:0]        mag;
    logic [3:0]        quot;
    logic [7:0]        used;
    logic [3:0]        rem;
    logic signed [4:0] delta;
    logic signed [9:0] pend_sum;
    logic signed [7:0] pend_sat;

    always_comb
    begin
        if (steps_per_detent < DETENT_MIN) begin
            spd = DETENT_MIN;
        end else if (steps_per_detent > DETENT_MAX) begin
            spd = DETENT_MAX;
        end else begin
            spd = steps_per_detent;
        end

        pins = {pin_a, pin_b};
        sum5 = 5'(step_sum_reg) + 5'(gray_step({last_pins_reg, pins}));
        mag5 = sum5[4] ? -sum5 : sum5;
        mag  = mag5[3:0];
        quot = detent_quot(mag, spd);
        used = {4'd0, quot} * {4'd0, spd};
        rem  = mag - used[3:0];
        delta = sum5[4] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

        last_pins_next = last_pins_reg;
        step_sum_next  = step_sum_reg;
        pend_sum       = 10'(pending_reg);
        if (pins != last_pins_reg) begin
            last_pins_next = pins;
            step_sum_next  = sum5[4] ? -$signed(rem) : $signed(rem);
            pend_sum       = 10'(pending_reg) + 10'(delta);
        end

        if (pend_sum > ROT_MAX) begin
            pend_sat = 8'(ROT_MAX);
        end else if (pend_sum < ROT_MIN) begin
            pend_sat = 8'(ROT_MIN);
        end else begin
            pend_sat = pend_sum[7:0];
        end

        rotation_taken = take ? pend_sat : 8'sd0;
        pending_next   = take ? 8'sd0 : pend_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_pins_reg <= PINS_IDLE;
            step_sum_reg  <= 4'sd0;
            pending_reg   <= 8'sd0;
        end else if (advance) begin
            last_pins_reg <= last_pins_next;
            step_sum_reg  <= step_sum_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

[hdl/encbtn_switch.sv]
`timescale 1ns / 1ps

module encbtn_switch
    import encbtn_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        take,
    input  logic        pressed,
    input  logic [7:0]  debounce_ticks,
    input  logic [15:0] long_press_ticks,
    input  logic [15:0] min_short_ticks,
    output sw_status_t  status
);

    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic                  raw_reg, raw_next;
    logic                  stable_reg, stable_next;
    logic [TIMER_BITS-1:0] since_reg, since_next;
    logic [TIMER_BITS-1:0] held_reg, held_next;
    logic                  long_fired_reg, long_fired_next;
    logic                  short_pend_reg, short_pend_next;
    logic                  long_pend_reg, long_pend_next;
    logic                  short_new, long_new;

    always_comb
    begin
        raw_next        = raw_reg;
        stable_next     = stable_reg;
        long_fired_next = long_fired_reg;
        short_new       = short_pend_reg;
        long_new        = long_pend_reg;

        held_next = (held_reg == '1) ? held_reg : held_reg + 1'b1;
        if (pressed != raw_reg) begin
            raw_next   = pressed;
            since_next = '0;
        end else begin
            since_next = (since_reg == '1) ? since_reg : since_reg + 1'b1;
        end

        if (CW'(since_next) >= CW'(debounce_ticks)) begin
            if (pressed != stable_reg) begin
                stable_next = pressed;
                if (pressed) begin
                    held_next       = '0;
                    long_fired_next = 1'b0;
                end else begin
                    if (!long_fired_reg && CW'(held_next) >= CW'(min_short_ticks)) begin
                        short_new = 1'b1;
                    end
                    long_fired_next = 1'b0;
                end
            end else if (stable_reg && !long_fired_reg
                         && CW'(held_next) >= CW'(long_press_ticks)) begin
                long_fired_next = 1'b1;
                long_new        = 1'b1;
            end
        end

        status.stable      = stable_next;
        status.short_taken = take & short_new;
        status.long_taken  = take & long_new;
        short_pend_next    = short_new & ~take;
        long_pend_next     = long_new & ~take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            raw_reg        <= 1'b0;
            stable_reg     <= 1'b0;
            since_reg      <= '0;
            held_reg       <= '0;
            long_fired_reg <= 1'b0;
            short_pend_reg <= 1'b0;
            long_pend_reg  <= 1'b0;
        end else if (advance) begin
            raw_reg        <= raw_next;
            stable_reg     <= stable_next;
            since_reg      <= since_next;
            held_reg       <= held_next;
            long_fired_reg <= long_fired_next;
            short_pend_reg <= short_pend_next;
            long_pend_reg  <= long_pend_next;
        end
    end

endmodule
